[rtl/core/sldf_pkg.sv]
`default_nettype none

package sldf_pkg;

    localparam int MAX_PAYLOAD_DEF = 512;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int INDEX_W  = 9;
    localparam int KIND_W   = 2;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_CMD_HI  = 3'd4,
        PH_CMD_LO  = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_CHECK   = 3'd7
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        EV_DATA   = 2'd0,
        EV_OK     = 2'd1,
        EV_BADSUM = 2'd2,
        EV_BADLEN = 2'd3
    } event_kind_t;

    typedef struct packed {
        event_kind_t         event_kind;
        logic [BYTE_W-1:0]   data_byte;
        logic [WORD_W-1:0]   command;
        logic [WORD_W-1:0]   payload_length;
        logic [INDEX_W-1:0]  byte_index;
    } result_t;

endpackage

`default_nettype wire

[rtl/core/sync_length_checksum_deframer_unit.sv]
// Byte-stream deframer. Received bytes enter on the s_ channel, one per
// transaction, and the block hunts for the sync pair 0x55, 0xAA, then reads
// a big-endian length, a big-endian command, the payload and a checksum byte.
// Each payload byte leaves on the m_ channel as one transaction tagged with
// the command, the declared length and its index; the checksum byte gives a
// frame-accepted or checksum-mismatch transaction, and a length above
// MAX_PAYLOAD gives a length-error transaction straight after the length.
// Sync, command and in-range length bytes produce no output transaction.
// Each byte is handled as it is taken: the frame state updates at the input
// transaction and any result is registered, so it appears on the m_ channel
// the cycle after the byte is taken. One byte per cycle is sustained while
// the receiver keeps up.
// When the receiver stalls with a result held, s_ready stays low until that
// result is taken; otherwise bytes keep flowing.
// After the synchronous, active-low reset the block hunts for the first sync
// byte and holds no result.
`default_nettype none

module sync_length_checksum_deframer_unit #(
    parameter int MAX_PAYLOAD = sldf_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [sldf_pkg::BYTE_W-1:0]   s_rx_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [sldf_pkg::KIND_W-1:0]        m_event_kind,
    output logic [sldf_pkg::BYTE_W-1:0]        m_data_byte,
    output logic [sldf_pkg::WORD_W-1:0]        m_command,
    output logic [sldf_pkg::WORD_W-1:0]        m_payload_length,
    output logic [sldf_pkg::INDEX_W-1:0]       m_byte_index
);
    import sldf_pkg::*;

    logic    accept;
    logic    res_valid;
    result_t res;
    result_t m_res;

    assign accept = s_valid && s_ready;

    sldf_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .rx_byte   (s_rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    sldf_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .res_valid (res_valid),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_event_kind     = m_res.event_kind;
    assign m_data_byte      = m_res.data_byte;
    assign m_command        = m_res.command;
    assign m_payload_length = m_res.payload_length;
    assign m_byte_index     = m_res.byte_index;

endmodule

`default_nettype wire

[rtl/core/sldf_parser.sv]
`default_nettype none

module sldf_parser #(
    parameter int MAX_PAYLOAD = sldf_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        accept,
    input  wire logic [sldf_pkg::BYTE_W-1:0] rx_byte,
    output logic                             res_valid,
    output sldf_pkg::result_t                res
);
    import sldf_pkg::*;

    localparam int CNT_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    phase_t              phase_reg, phase_next;
    logic [WORD_W-1:0]   len_reg, len_next;
    logic [WORD_W-1:0]   cmd_reg, cmd_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [BYTE_W-1:0]   sum_reg, sum_next;

    logic [WORD_W-1:0]   cnt_ext;
    logic [WORD_W-1:0]   len_full;
    logic [BYTE_W-1:0]   sum_add;

    assign cnt_ext  = WORD_W'(cnt_reg);
    assign len_full = {len_reg[WORD_W-1:BYTE_W], rx_byte};
    assign sum_add  = sum_reg + rx_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            len_reg   <= '0;
            cmd_reg   <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cmd_reg   <= cmd_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
        end
    end

    always_comb begin
        phase_next         = phase_reg;
        len_next           = len_reg;
        cmd_next           = cmd_reg;
        cnt_next           = cnt_reg;
        sum_next           = sum_reg;
        res_valid          = 1'b0;
        res.event_kind     = EV_DATA;
        res.data_byte      = '0;
        res.command        = cmd_reg;
        res.payload_length = len_reg;
        res.byte_index     = '0;
        case (phase_reg)
            PH_HUNT: begin
                if (rx_byte == SYNC_FIRST) begin
                    phase_next = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                if (rx_byte == SYNC_SECOND) begin
                    sum_next   = SYNC_FIRST + SYNC_SECOND;
                    phase_next = PH_LEN_HI;
                end else if (rx_byte != SYNC_FIRST) begin
                    phase_next = PH_HUNT;
                end
            end
            PH_LEN_HI: begin
                len_next   = {rx_byte, {BYTE_W{1'b0}}};
                sum_next   = sum_add;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len_next = len_full;
                sum_next = sum_add;
                if (len_full > WORD_W'(MAX_PAYLOAD)) begin
                    res_valid          = 1'b1;
                    res.event_kind     = EV_BADLEN;
                    res.command        = '0;
                    res.payload_length = len_full;
                    phase_next         = PH_HUNT;
                end else begin
                    phase_next = PH_CMD_HI;
                end
            end
            PH_CMD_HI: begin
                cmd_next   = {rx_byte, {BYTE_W{1'b0}}};
                sum_next   = sum_add;
                phase_next = PH_CMD_LO;
            end
            PH_CMD_LO: begin
                cmd_next   = {cmd_reg[WORD_W-1:BYTE_W], rx_byte};
                sum_next   = sum_add;
                cnt_next   = '0;
                phase_next = (len_reg == '0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                sum_next       = sum_add;
                res_valid      = 1'b1;
                res.event_kind = EV_DATA;
                res.data_byte  = rx_byte;
                res.byte_index = cnt_ext[INDEX_W-1:0];
                if ((cnt_ext + WORD_W'(1)) >= len_reg) begin
                    phase_next = PH_CHECK;
                end else begin
                    cnt_next = CNT_W'(cnt_ext + WORD_W'(1));
                end
            end
            PH_CHECK: begin
                res_valid      = 1'b1;
                res.event_kind = (rx_byte == sum_reg) ? EV_OK : EV_BADSUM;
                phase_next     = PH_HUNT;
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    a_check_returns_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && phase_reg == PH_CHECK |=> phase_reg == PH_HUNT)
        else $error("Checksum byte did not return the parser to hunting.");

    a_count_within_length: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> cnt_ext < len_reg)
        else $error("Payload count has reached the declared length.");

    a_result_phases: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (phase_reg == PH_LEN_LO || phase_reg == PH_PAYLOAD ||
                       phase_reg == PH_CHECK))
        else $error("Result raised in a phase that produces none.");

    a_length_within_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_CMD_HI |-> len_reg <= WORD_W'(MAX_PAYLOAD))
        else $error("Frame with an oversized length reached the command phase.");

endmodule

`default_nettype wire

[rtl/core/sldf_out_reg.sv]
`default_nettype none

module sldf_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              res_valid,
    input  wire sldf_pkg::result_t res,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output sldf_pkg::result_t      m_res
);
    import sldf_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;
    logic    load;

    assign s_ready    = !valid_reg || m_ready;
    assign load       = s_valid && s_ready && res_valid;
    assign valid_next = s_ready ? load : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    a_load_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid && m_res == $past(res))
        else $error("Loaded result does not appear on the output.");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("Input accepted while the held result is stalled.");

endmodule

`default_nettype wire

[verif/tb_top.sv]
`default_nettype none

module tb_top;
    import sldf_pkg::*;

    localparam int MAX_LEN = MAX_PAYLOAD_DEF;
    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM = 1650;

    typedef struct {
        logic [BYTE_W-1:0] rx;
        bit                fixed;
        bit                has_event;
        result_t           ev;
    } directed_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_rx_byte = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [KIND_W-1:0]    m_event_kind;
    logic [BYTE_W-1:0]    m_data_byte;
    logic [WORD_W-1:0]    m_command;
    logic [WORD_W-1:0]    m_payload_length;
    logic [INDEX_W-1:0]   m_byte_index;

    phase_t               frame_phase = PH_HUNT;
    logic [WORD_W-1:0]    pred_len = '0;
    logic [WORD_W-1:0]    frame_cmd = '0;
    logic [9:0]           payload_cnt = '0;
    logic [BYTE_W-1:0]    frame_sum = '0;

    result_t              pending_events[$];
    int                   mismatches = 0;
    int                   rx_count = 0;
    int                   send_gap_pct = 35;
    int                   stall_pct = 35;

    // Rows with a fixed expectation are checked against it; the rest against the predictor.
    directed_row_t directed_rows [N_DIRECTED] = '{
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b0, '0},
        '{8'h55, 1'b1, 1'b0, '0},
        '{8'h55, 1'b1, 1'b0, '0},
        '{8'hAA, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b1, '{EV_BADLEN, 8'h00, 16'h0000, 16'hFFFF, 9'd0}},
        '{8'h55, 1'b1, 1'b0, '0},
        '{8'hAA, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b0, '0},
        '{8'hFD, 1'b1, 1'b1, '{EV_OK, 8'h00, 16'hFFFF, 16'h0000, 9'd0}},
        '{8'h55, 1'b0, 1'b0, '0},
        '{8'h12, 1'b0, 1'b0, '0},
        '{8'h55, 1'b0, 1'b0, '0},
        '{8'hAA, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h02, 1'b0, 1'b0, '0},
        '{8'h12, 1'b0, 1'b0, '0},
        '{8'h34, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h47, 1'b1, 1'b1, '{EV_BADSUM, 8'h00, 16'h1234, 16'h0002, 9'd0}}
    };

    sync_length_checksum_deframer_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_data_byte      (m_data_byte),
        .m_command        (m_command),
        .m_payload_length (m_payload_length),
        .m_byte_index     (m_byte_index)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output result_t ev);
        bit produced;
        produced = 1'b0;
        ev = '0;
        case (frame_phase)
            PH_HUNT: begin
                if (b == SYNC_FIRST) frame_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (b == SYNC_SECOND) begin
                    frame_sum = SYNC_FIRST + SYNC_SECOND;
                    frame_phase = PH_LEN_HI;
                end else if (b != SYNC_FIRST) begin
                    frame_phase = PH_HUNT;
                end
            end
            PH_LEN_HI: begin
                pred_len = {b, 8'h00};
                frame_sum = frame_sum + b;
                frame_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                pred_len[7:0] = b;
                frame_sum = frame_sum + b;
                if (pred_len > MAX_LEN) begin
                    ev.event_kind = EV_BADLEN;
                    ev.payload_length = pred_len;
                    produced = 1'b1;
                    frame_phase = PH_HUNT;
                end else begin
                    frame_phase = PH_CMD_HI;
                end
            end
            PH_CMD_HI: begin
                frame_cmd = {b, 8'h00};
                frame_sum = frame_sum + b;
                frame_phase = PH_CMD_LO;
            end
            PH_CMD_LO: begin
                frame_cmd[7:0] = b;
                frame_sum = frame_sum + b;
                payload_cnt = '0;
                frame_phase = (pred_len == 0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                frame_sum = frame_sum + b;
                ev.event_kind = EV_DATA;
                ev.data_byte = b;
                ev.command = frame_cmd;
                ev.payload_length = pred_len;
                ev.byte_index = payload_cnt[INDEX_W-1:0];
                produced = 1'b1;
                if (32'(payload_cnt) + 1 >= 32'(pred_len)) frame_phase = PH_CHECK;
                else payload_cnt = payload_cnt + 1'b1;
            end
            default: begin
                ev.event_kind = (b == frame_sum) ? EV_OK : EV_BADSUM;
                ev.command = frame_cmd;
                ev.payload_length = pred_len;
                produced = 1'b1;
                frame_phase = PH_HUNT;
            end
        endcase
        return produced;
    endfunction

    task automatic drive_byte(input logic [BYTE_W-1:0] rx, input bit fixed,
                              input bit fixed_has, input result_t fixed_ev);
        result_t ev;
        bit has;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        has = deframe_byte(rx, ev);
        if (fixed) begin
            has = fixed_has;
            ev = fixed_ev;
        end
        if (has) pending_events.push_back(ev);
        s_valid <= 1'b1;
        s_rx_byte <= rx;
        do @(posedge aclk); while (!s_ready);
        rx_count++;
    endtask

    task automatic drain_events();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_events.size() != 0);
    endtask

    task automatic send_frame(input logic [WORD_W-1:0] flen, input bit corrupt);
        logic [WORD_W-1:0] cmd;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        cmd = WORD_W'($urandom);
        sum = SYNC_FIRST + SYNC_SECOND + flen[15:8] + flen[7:0] + cmd[15:8] + cmd[7:0];
        drive_byte(SYNC_FIRST, 1'b0, 1'b0, '0);
        drive_byte(SYNC_SECOND, 1'b0, 1'b0, '0);
        drive_byte(flen[15:8], 1'b0, 1'b0, '0);
        drive_byte(flen[7:0], 1'b0, 1'b0, '0);
        drive_byte(cmd[15:8], 1'b0, 1'b0, '0);
        drive_byte(cmd[7:0], 1'b0, 1'b0, '0);
        for (int i = 0; i < int'(flen); i++) begin
            b = BYTE_W'($urandom);
            sum = sum + b;
            drive_byte(b, 1'b0, 1'b0, '0);
        end
        if (corrupt) sum = sum + BYTE_W'($urandom_range(1, 255));
        drive_byte(sum, 1'b0, 1'b0, '0);
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        result_t exp_ev;
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected result transaction: kind %0d data %0h", m_event_kind,
                       m_data_byte);
                mismatches++;
            end else begin
                exp_ev = pending_events.pop_front();
                if (m_event_kind != exp_ev.event_kind) begin
                    $error("event_kind: expected %0d, got %0d", exp_ev.event_kind,
                           m_event_kind);
                    mismatches++;
                end
                if (m_data_byte != exp_ev.data_byte) begin
                    $error("data_byte: expected %0h, got %0h", exp_ev.data_byte, m_data_byte);
                    mismatches++;
                end
                if (m_command != exp_ev.command) begin
                    $error("command: expected %0h, got %0h", exp_ev.command, m_command);
                    mismatches++;
                end
                if (m_payload_length != exp_ev.payload_length) begin
                    $error("payload_length: expected %0d, got %0d", exp_ev.payload_length,
                           m_payload_length);
                    mismatches++;
                end
                if (m_byte_index != exp_ev.byte_index) begin
                    $error("byte_index: expected %0d, got %0d", exp_ev.byte_index,
                           m_byte_index);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int frame_no;
        int pick;
        bit calm;
        logic [WORD_W-1:0] flen;
        logic [BYTE_W-1:0] b;
        frame_no = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            drive_byte(directed_rows[i].rx, directed_rows[i].fixed,
                       directed_rows[i].has_event, directed_rows[i].ev);
        end
        drain_events();

        while (rx_count < N_DIRECTED + N_RANDOM) begin
            calm = (rx_count >= 900 && rx_count < 1200);
            send_gap_pct = calm ? 0 : 35;
            stall_pct = calm ? 0 : 35;
            frame_no++;
            if (frame_no % 40 == 0) drain_events();
            if (frame_no == 5) begin
                flen = WORD_W'(MAX_LEN);
            end else if ($urandom_range(0, 39) == 0) begin
                flen = WORD_W'($urandom_range(MAX_LEN - 8, MAX_LEN));
            end else begin
                flen = WORD_W'($urandom_range(0, 12));
            end
            pick = $urandom_range(0, 99);
            if (frame_no == 5 || pick < 60) begin
                send_frame(flen, 1'b0);
            end else if (pick < 72) begin
                send_frame(flen, 1'b1);
            end else if (pick < 80) begin
                flen = $urandom_range(0, 1) ? WORD_W'(MAX_LEN + 1)
                                            : WORD_W'($urandom_range(MAX_LEN + 1, 65535));
                drive_byte(SYNC_FIRST, 1'b0, 1'b0, '0);
                drive_byte(SYNC_SECOND, 1'b0, 1'b0, '0);
                drive_byte(flen[15:8], 1'b0, 1'b0, '0);
                drive_byte(flen[7:0], 1'b0, 1'b0, '0);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 3) == 0) begin
                        b = $urandom_range(0, 1) ? SYNC_FIRST : SYNC_SECOND;
                    end else begin
                        b = BYTE_W'($urandom);
                    end
                    drive_byte(b, 1'b0, 1'b0, '0);
                end
            end else begin
                repeat ($urandom_range(1, 3)) drive_byte(SYNC_FIRST, 1'b0, 1'b0, '0);
                send_frame(flen, $urandom_range(0, 3) == 0);
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_events.size() != 0);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending_events.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
